>>> rtl/polyphase_decimation_fir_defines.svh
// Assertion macros for the polyphase decimator.
// Each assertion is clocked on clk and held off while rst_n is low.
`ifndef POLYPHASE_DECIMATION_FIR_DEFINES_SVH
`define POLYPHASE_DECIMATION_FIR_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define PDF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pdf assertion failed");

// The expression must never be true at a clock edge outside reset.
`define PDF_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pdf forbidden condition seen");

`else

`define PDF_ASSERT(lbl, prop)
`define PDF_ASSERT_NEVER(lbl, expr)

`endif

`endif

>>> rtl/pdf_pkg.sv
package pdf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 6;
    localparam int PROD_W   = 32;
    localparam int OUT_W    = 38;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_COEF = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_EMIT  = 4'b1000
    } pdf_state_t;

    // Tag that travels alongside the RAM read data into the MAC.
    typedef struct packed {
        logic vld;
        logic first;
    } pdf_mac_ctl_t;

endpackage

>>> rtl/pdf_ram.sv
module pdf_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pdf_mac.sv
module pdf_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pdf_pkg::pdf_mac_ctl_t                ctl,
    input  logic signed [pdf_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [pdf_pkg::COEF_W-1:0]    coef,
    output logic signed [pdf_pkg::OUT_W-1:0]     acc,
    output logic                                 busy
);

    import pdf_pkg::*;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    pdf_mac_ctl_t             ctl_reg;
    logic signed [OUT_W-1:0]  acc_reg;

    assign prod_next = PROD_W'(sample) * PROD_W'(coef);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl_reg.vld)
        begin
            // first product of a decimation group restarts the sum; wraps mod 2^38
            if (ctl_reg.first)
            begin
                acc_reg <= OUT_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + OUT_W'(prod_reg);
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = ctl_reg.vld;

endmodule

>>> rtl/polyphase_decimation_fir.sv
// Polyphase decimating FIR. A push item (command 0) shifts one Q1.15 sample into a
// DECIMATION*SUB_TAPS tap window; every DECIMATION-th push yields one exact Q8.30 sum
// on filtered, coefficient 0 weighting the oldest sample. A coefficient item
// (command 1) loads one slot; slots at or beyond the tap count are ignored. The window
// is a circular buffer in one RAM and the coefficients sit in a second RAM; one shared
// multiply-accumulate takes one read from each per cycle. After a push that does not
// close a decimation group the block stays ready for the next item. The push that
// closes a group runs the whole window against the coefficients held at that time:
// it is accepted, DECIMATION*SUB_TAPS reads follow, the MAC pipeline drains and the
// result is loaded. The load waits while the previous result is still untaken;
// otherwise a pending result does not block new items. After reset both RAMs are
// cleared, one entry per cycle, with in_ready low until every entry is zero.
`include "polyphase_decimation_fir_defines.svh"

module polyphase_decimation_fir #(
    parameter int DECIMATION = 4,
    parameter int SUB_TAPS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic signed [pdf_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [pdf_pkg::IDX_W-1:0]            coef_index,
    input  logic signed [pdf_pkg::COEF_W-1:0]    coef_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pdf_pkg::OUT_W-1:0]     filtered
);

    import pdf_pkg::*;

    localparam int TAPS = DECIMATION * SUB_TAPS;
    localparam int AW   = $clog2(TAPS);
    localparam int PW   = $clog2(DECIMATION);
    localparam int CNTW = $clog2(TAPS + 1);
    localparam int CMPW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

    pdf_state_t   state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] win_ra_reg, win_ra_next;
    logic [AW-1:0] coef_ra_reg, coef_ra_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    pdf_mac_ctl_t  rd_ctl_reg, rd_ctl_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] filtered_reg;
    logic          load_out;

    logic          accept;
    logic          clearing;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] win_dec;
    logic [CMPW-1:0] coef_index_ext;
    logic          idx_ok;

    logic            win_we;
    logic [AW-1:0]   win_waddr;
    logic [SAMPLE_W-1:0] win_wdata;
    logic [SAMPLE_W-1:0] win_rdata;
    logic            coef_we;
    logic [AW-1:0]   coef_waddr;
    logic [COEF_W-1:0] coef_wdata;
    logic [COEF_W-1:0] coef_rdata;

    logic signed [OUT_W-1:0] acc;
    logic                    mac_busy;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign clearing = (state_reg == ST_CLEAR);

    assign wp_inc = (wp_reg == AW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;

    // walk back one age through the circular window
    assign win_dec = (win_ra_reg == '0) ? AW'(TAPS - 1) : win_ra_reg - 1'b1;

    assign coef_index_ext = CMPW'(coef_index);
    assign idx_ok         = coef_index_ext < CMPW'(TAPS);

    assign win_we    = clearing || (accept && command == CMD_PUSH);
    assign win_waddr = clearing ? clr_addr_reg : wp_inc;
    assign win_wdata = clearing ? '0 : sample_in;

    assign coef_we    = clearing || (accept && command == CMD_COEF && idx_ok);
    assign coef_waddr = clearing ? clr_addr_reg : coef_index_ext[AW-1:0];
    assign coef_wdata = clearing ? '0 : coef_value;

    pdf_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_ra_reg),
        .rdata (win_rdata)
    );

    pdf_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (COEF_W)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_ra_reg),
        .rdata (coef_rdata)
    );

    pdf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rd_ctl_reg),
        .sample (signed'(win_rdata)),
        .coef   (signed'(coef_rdata)),
        .acc    (acc),
        .busy   (mac_busy)
    );

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        clr_addr_next  = clr_addr_reg;
        win_ra_next    = win_ra_reg;
        coef_ra_next   = coef_ra_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        rd_ctl_next    = '0;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(TAPS - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && command == CMD_PUSH)
                begin
                    wp_next = wp_inc;
                    if (phase_reg == PW'(DECIMATION - 1))
                    begin
                        // group closed: newest sample meets coefficient TAPS-1
                        phase_next   = '0;
                        win_ra_next  = wp_inc;
                        coef_ra_next = AW'(TAPS - 1);
                        cnt_next     = '0;
                        state_next   = ST_RUN;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != CNTW'(TAPS))
                begin
                    rd_ctl_next.vld   = 1'b1;
                    rd_ctl_next.first = (cnt_reg == '0);
                    cnt_next          = cnt_reg + 1'b1;
                    win_ra_next       = win_dec;
                    coef_ra_next      = coef_ra_reg - 1'b1;
                end
                else if (!rd_ctl_reg.vld && !mac_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            clr_addr_reg  <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            rd_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            clr_addr_reg  <= clr_addr_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            rd_ctl_reg    <= rd_ctl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_ra_reg  <= win_ra_next;
        coef_ra_reg <= coef_ra_next;
        if (load_out)
        begin
            filtered_reg <= acc;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // no new item while the MAC pipeline still holds reads
    `PDF_ASSERT_NEVER(a_no_accept_busy, in_ready && (rd_ctl_reg.vld || mac_busy))

    // a result appears only after the last push of a decimation group
    `PDF_ASSERT(a_emit_on_last_phase, $rose(out_valid) |-> (phase_reg == '0))

    // circular write pointer stays inside the window
    `PDF_ASSERT(a_wp_in_range, wp_reg <= AW'(TAPS - 1))

endmodule
